>>> design/cdr_pkg.sv
// ----------------------------------------------------------------------------
// cdr_pkg
// Shared codes, register indexes and types of the counter delta rate block.
// ----------------------------------------------------------------------------
`default_nettype none
package cdr_pkg;

    localparam logic [2:0] RC_OK          = 3'd0;
    localparam logic [2:0] RC_BAD_CONTEXT = 3'd1;
    localparam logic [2:0] RC_BAD_SAMPLES = 3'd2;
    localparam logic [2:0] RC_EPOCH       = 3'd3;
    localparam logic [2:0] RC_BAD_TIME    = 3'd4;
    localparam logic [2:0] RC_TOO_SHORT   = 3'd5;
    localparam logic [2:0] RC_GAP         = 3'd6;
    localparam logic [2:0] RC_RESET       = 3'd7;

    localparam logic [2:0] REG_MIN_INTERVAL  = 3'd0;
    localparam logic [2:0] REG_MAX_GAP       = 3'd1;
    localparam logic [2:0] REG_WRAP_ENABLE   = 3'd2;
    localparam logic [2:0] REG_WRAP_MODULUS  = 3'd3;
    localparam logic [2:0] REG_WRAP_MIN_PREV = 3'd4;
    localparam logic [2:0] REG_WRAP_MAX_CUR  = 3'd5;
    localparam logic [2:0] REG_RATE_ENABLE   = 3'd6;

    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;

    typedef struct packed {
        logic [2:0]  code;
        logic [63:0] delta;
        logic [62:0] interval;
        logic        rate_en;
    } t_job;

endpackage
`default_nettype wire

>>> design/cdr_ifs.sv
// ----------------------------------------------------------------------------
// cdr_ifs
// Channel interfaces of the counter delta rate block.
// ----------------------------------------------------------------------------
`default_nettype none
interface cdr_in_if;
    logic        valid;
    logic        ready;
    logic        context_ok;
    logic [62:0] eval_time;
    logic [62:0] first_time;
    logic [63:0] first_value;
    logic [31:0] first_epoch;
    logic        first_ok;
    logic [62:0] second_time;
    logic [63:0] second_value;
    logic [31:0] second_epoch;
    logic        second_ok;
    modport source (output valid, context_ok, eval_time, first_time, first_value,
                    first_epoch, first_ok, second_time, second_value, second_epoch,
                    second_ok, input ready);
    modport sink (input valid, context_ok, eval_time, first_time, first_value,
                  first_epoch, first_ok, second_time, second_value, second_epoch,
                  second_ok, output ready);
endinterface

interface cdr_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  result_code;
    logic [63:0] delta;
    logic        rate_valid;
    logic [63:0] rate;
    logic        rate_saturated;
    modport source (output valid, result_code, delta, rate_valid, rate,
                    rate_saturated, input ready);
    modport sink (input valid, result_code, delta, rate_valid, rate,
                  rate_saturated, output ready);
endinterface

interface cdr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> design/cdr_front.sv
// ----------------------------------------------------------------------------
// cdr_front
// Holds the configuration registers, orders the samples, runs the checks and
// forms the delta of each accepted transfer.
// ----------------------------------------------------------------------------
`default_nettype none
module cdr_front #(
    parameter int EPOCH_BITS = 32
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    cdr_in_if.sink        i_in,
    cdr_cfg_if.sink       i_cfg,
    input  wire           i_q_ready,
    output logic          o_q_valid,
    output cdr_pkg::t_job o_q_job
);
    localparam int EB = (EPOCH_BITS > 32) ? 32 : EPOCH_BITS;

    logic [62:0] r_min_interval, r_max_gap;
    logic        r_wrap_enable, r_rate_enable;
    logic [63:0] r_wrap_modulus, r_wrap_min_prev, r_wrap_max_cur;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_interval  <= 63'd1;
            r_max_gap       <= {63{1'b1}};
            r_wrap_enable   <= 1'b0;
            r_wrap_modulus  <= 64'h1_0000_0000;
            r_wrap_min_prev <= 64'h8000_0000;
            r_wrap_max_cur  <= 64'h7FFF_FFFF;
            r_rate_enable   <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                cdr_pkg::REG_MIN_INTERVAL:  r_min_interval  <= i_cfg.data[62:0];
                cdr_pkg::REG_MAX_GAP:       r_max_gap       <= i_cfg.data[62:0];
                cdr_pkg::REG_WRAP_ENABLE:   r_wrap_enable   <= i_cfg.data[0];
                cdr_pkg::REG_WRAP_MODULUS:  r_wrap_modulus  <= i_cfg.data;
                cdr_pkg::REG_WRAP_MIN_PREV: r_wrap_min_prev <= i_cfg.data;
                cdr_pkg::REG_WRAP_MAX_CUR:  r_wrap_max_cur  <= i_cfg.data;
                cdr_pkg::REG_RATE_ENABLE:   r_rate_enable   <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    logic        swap;
    logic [62:0] t_old, t_new, interval;
    logic [63:0] v_old, v_new;

    assign swap     = i_in.second_time < i_in.first_time;
    assign t_old    = swap ? i_in.second_time : i_in.first_time;
    assign t_new    = swap ? i_in.first_time : i_in.second_time;
    assign v_old    = swap ? i_in.second_value : i_in.first_value;
    assign v_new    = swap ? i_in.first_value : i_in.second_value;
    assign interval = t_new - t_old;

    always_comb begin
        o_q_job.delta    = 64'd0;
        o_q_job.code     = cdr_pkg::RC_OK;
        o_q_job.interval = interval;
        o_q_job.rate_en  = r_rate_enable;
        priority if (!i_in.context_ok) begin
            o_q_job.code = cdr_pkg::RC_BAD_CONTEXT;
        end else if (!i_in.first_ok || !i_in.second_ok) begin
            o_q_job.code = cdr_pkg::RC_BAD_SAMPLES;
        end else if (i_in.first_epoch[EB-1:0] != i_in.second_epoch[EB-1:0]) begin
            o_q_job.code = cdr_pkg::RC_EPOCH;
        end else if (t_new <= t_old || i_in.eval_time < t_new) begin
            o_q_job.code = cdr_pkg::RC_BAD_TIME;
        end else if (interval < r_min_interval) begin
            o_q_job.code = cdr_pkg::RC_TOO_SHORT;
        end else if (interval > r_max_gap) begin
            o_q_job.code = cdr_pkg::RC_GAP;
        end else if (v_new >= v_old) begin
            o_q_job.delta = v_new - v_old;
        end else if (r_wrap_enable && v_old >= r_wrap_min_prev &&
                     v_old < r_wrap_modulus && v_new <= r_wrap_max_cur) begin
            o_q_job.delta = (r_wrap_modulus - v_old) + v_new;
        end else begin
            o_q_job.code = cdr_pkg::RC_RESET;
        end
    end

    assign o_q_valid  = i_in.valid;
    assign i_in.ready = i_q_ready;

endmodule
`default_nettype wire

>>> design/cdr_fifo.sv
// ----------------------------------------------------------------------------
// cdr_fifo
// Two-entry queue that decouples the checking front from the rate back end.
// ----------------------------------------------------------------------------
`default_nettype none
module cdr_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_wr_valid,
    output logic          o_wr_ready,
    input  cdr_pkg::t_job i_wr_job,
    output logic          o_rd_valid,
    input  wire           i_rd_ready,
    output cdr_pkg::t_job o_rd_job
);
    cdr_pkg::t_job r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          push, pop;

    assign o_wr_ready = r_cnt != 2'd2;
    assign o_rd_valid = r_cnt != 2'd0;
    assign o_rd_job   = r_mem[r_rp];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_wr_job;
    end

endmodule
`default_nettype wire

>>> design/cdr_back.sv
// ----------------------------------------------------------------------------
// cdr_back
// Rate pipeline: split multiply by 1e9, fraction shift, saturation compare and
// a one-bit-per-stage restoring divider, ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module cdr_back #(
    parameter int RATE_FRAC_BITS = 16
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  cdr_pkg::t_job i_job,
    cdr_out_if.source     o_out
);
    localparam int QB = 64;

    logic          adv;
    logic          r_a_v, r_b_v;
    logic [61:0]   r_a_plo, r_a_phi;
    cdr_pkg::t_job r_a_job, r_b_job;
    logic [63:0]   r_b_hi, r_b_lo;
    logic [93:0]   product;
    logic [127:0]  dividend;

    logic          r_v   [QB+1];
    cdr_pkg::t_job r_job [QB+1];
    logic          r_sat [QB+1];
    logic [62:0]   r_rem [QB+1];
    logic [63:0]   r_lo  [QB+1];
    logic [63:0]   r_q   [QB+1];
    logic [62:0]   n_rem [QB+1];
    logic [63:0]   n_q   [QB+1];

    assign adv     = !r_v[QB] || o_out.ready;
    assign o_ready = adv;

    assign product  = {r_a_phi, 32'd0} + {32'd0, r_a_plo};
    assign dividend = {34'd0, product} << RATE_FRAC_BITS;

    always_comb begin
        logic [63:0] t;
        t = 64'd0;
        n_rem[0] = r_rem[0];
        n_q[0]   = r_q[0];
        for (int k = 0; k < QB; k++) begin
            t = {r_rem[k], r_lo[k][63]};
            if (t >= {1'b0, r_job[k].interval}) begin
                n_rem[k+1] = 63'(t - {1'b0, r_job[k].interval});
                n_q[k+1]   = {r_q[k][62:0], 1'b1};
            end else begin
                n_rem[k+1] = t[62:0];
                n_q[k+1]   = {r_q[k][62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            for (int k = 0; k <= QB; k++) r_v[k] <= 1'b0;
        end else if (adv) begin
            r_a_v <= i_valid;
            r_b_v <= r_a_v;
            r_v[0] <= r_b_v;
            for (int k = 0; k < QB; k++) r_v[k+1] <= r_v[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_plo <= {30'd0, i_job.delta[31:0]} * {32'd0, cdr_pkg::NS_PER_SEC};
            r_a_phi <= {30'd0, i_job.delta[63:32]} * {32'd0, cdr_pkg::NS_PER_SEC};
            r_a_job <= i_job;
            r_b_hi  <= dividend[127:64];
            r_b_lo  <= dividend[63:0];
            r_b_job <= r_a_job;
            r_job[0] <= r_b_job;
            r_sat[0] <= r_b_hi >= {1'b0, r_b_job.interval};
            r_rem[0] <= r_b_hi[62:0];
            r_lo[0]  <= r_b_lo;
            r_q[0]   <= 64'd0;
            for (int k = 0; k < QB; k++) begin
                r_job[k+1] <= r_job[k];
                r_sat[k+1] <= r_sat[k];
                r_rem[k+1] <= n_rem[k+1];
                r_lo[k+1]  <= {r_lo[k][62:0], 1'b0};
                r_q[k+1]   <= n_q[k+1];
            end
        end
    end

    logic rv;
    assign rv                   = (r_job[QB].code == cdr_pkg::RC_OK) && r_job[QB].rate_en;
    assign o_out.valid          = r_v[QB];
    assign o_out.result_code    = r_job[QB].code;
    assign o_out.delta          = r_job[QB].delta;
    assign o_out.rate_valid     = rv;
    assign o_out.rate_saturated = rv && r_sat[QB];
    assign o_out.rate           = !rv ? 64'd0 : (r_sat[QB] ? {64{1'b1}} : r_q[QB]);

endmodule
`default_nettype wire

>>> design/counter_delta_rate_core.sv
// ----------------------------------------------------------------------------
// counter_delta_rate_core
// Delta and saturating fixed-point rate of a counter from two samples.
// ----------------------------------------------------------------------------
// A new sample pair is taken every cycle while the output is not stalled.
// Each result passes the registers of the split multiply by 1e9 and the
// fraction shift, then the saturation compare register, and then the
// one-bit-per-stage divider whose last stage is the output register. A
// two-entry queue between the checks and the rate pipeline lets either side
// stall on its own. Configuration writes are taken at any time.
`default_nettype none
module counter_delta_rate_core #(
    parameter int RATE_FRAC_BITS = 16,
    parameter int EPOCH_BITS     = 32
) (
    input  wire       i_clk,
    input  wire       i_rst_n,
    cdr_in_if.sink    i_in,
    cdr_cfg_if.sink   i_cfg,
    cdr_out_if.source o_out
);
    logic          f_valid, f_ready, b_valid, b_ready;
    cdr_pkg::t_job f_job, b_job;

    cdr_front #(.EPOCH_BITS(EPOCH_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_cfg(i_cfg),
        .i_q_ready(f_ready), .o_q_valid(f_valid), .o_q_job(f_job)
    );

    cdr_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_wr_valid(f_valid), .o_wr_ready(f_ready), .i_wr_job(f_job),
        .o_rd_valid(b_valid), .i_rd_ready(b_ready), .o_rd_job(b_job)
    );

    cdr_back #(.RATE_FRAC_BITS(RATE_FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_job(b_job), .o_out(o_out)
    );

endmodule
`default_nettype wire
